FILE: sv/mrf_pkg.sv
package mrf_pkg;

	localparam int unsigned FRAME_BYTES = 8;
	localparam int unsigned CNT_W = $clog2(FRAME_BYTES);

	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

	localparam logic [7:0] DEV_ADDR_RESET = 8'h01;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(FRAME_BYTES - 1);

	// crc-16/modbus update over one byte, reflected, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/modbus_request_framer.sv
// modbus rtu request framer: one request beat in, eight byte beats out
// first byte of a request leaves from the frame register, after the crc stages
// new requests are taken while a frame is still sent, unless every stage is full
// three crc stages (two bytes each) then a frame shift register that sends the bytes
// arst_n clears all valid bits, the byte counter, and sets device_address to 1
// the frame shift register and stage payloads are not reset
module modbus_request_framer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel (device_address)
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] register_address,
	input  logic [15:0] parameter_req,
	// byte channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last
);
	import mrf_pkg::*;

	// configured bus address
	logic [7:0] dev_addr_q;

	// stage 1: address and function code folded into the crc
	logic        vld_s1;
	logic [7:0]  dev_s1;
	logic [7:0]  fc_s1;
	logic [15:0] reg_s1;
	logic [15:0] par_s1;
	logic [15:0] crc_s1;

	// stage 2: register address bytes folded in
	logic        vld_s2;
	logic [7:0]  dev_s2;
	logic [7:0]  fc_s2;
	logic [15:0] reg_s2;
	logic [15:0] par_s2;
	logic [15:0] crc_s2;

	// stage 3: parameter bytes folded in, crc complete
	logic        vld_s3;
	logic [7:0]  dev_s3;
	logic [7:0]  fc_s3;
	logic [15:0] reg_s3;
	logic [15:0] par_s3;
	logic [15:0] crc_s3;

	// output frame register, first byte at the top
	logic                  out_valid_q;
	logic [8*FRAME_BYTES-1:0] frame_q;
	logic [CNT_W-1:0]      cnt_q;

	logic       out_fire;
	logic       frame_done;
	logic       ser_free;
	logic       en_s1;
	logic       en_s2;
	logic       en_s3;
	logic       load_ser;
	logic [7:0] fc_in;

	// configuration is always taken, the block is idle by contract
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	// handshake and stall chain
	assign out_fire   = out_valid_q && out_ready;
	assign frame_done = out_fire && (cnt_q == LAST_BEAT);
	assign ser_free   = !out_valid_q || frame_done;
	assign load_ser   = vld_s3 && ser_free;
	assign en_s3      = !vld_s3 || ser_free;
	assign en_s2      = !vld_s2 || en_s3;
	assign en_s1      = !vld_s1 || en_s2;
	assign in_ready   = en_s1;

	assign fc_in = action ? FC_WRITE_SINGLE : FC_READ_HOLDING;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dev_s1 <= dev_addr_q;
			fc_s1  <= fc_in;
			reg_s1 <= register_address;
			par_s1 <= parameter_req;
			crc_s1 <= crc16_byte(crc16_byte(CRC_INIT, dev_addr_q), fc_in);
		end
		if (en_s2 && vld_s1) begin
			dev_s2 <= dev_s1;
			fc_s2  <= fc_s1;
			reg_s2 <= reg_s1;
			par_s2 <= par_s1;
			crc_s2 <= crc16_byte(crc16_byte(crc_s1, reg_s1[15:8]), reg_s1[7:0]);
		end
		if (en_s3 && vld_s2) begin
			dev_s3 <= dev_s2;
			fc_s3  <= fc_s2;
			reg_s3 <= reg_s2;
			par_s3 <= par_s2;
			crc_s3 <= crc16_byte(crc16_byte(crc_s2, par_s2[15:8]), par_s2[7:0]);
		end
	end

	// serializer control: a new frame loads as the previous last byte leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_ser) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
			end else if (frame_done) begin
				out_valid_q <= 1'b0;
				cnt_q       <= '0;
			end else if (out_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// frame shift register, crc goes out low byte first
	always_ff @(posedge clk) begin
		if (load_ser) begin
			frame_q <= {dev_s3, fc_s3, reg_s3, par_s3, crc_s3[7:0], crc_s3[15:8]};
		end else if (out_fire) begin
			frame_q <= {frame_q[8*FRAME_BYTES-9:0], 8'h00};
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = frame_q[8*FRAME_BYTES-1 -: 8];
	assign last      = (cnt_q == LAST_BEAT);

	// a stalled stage 3 keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !en_s3 |=> vld_s3 && $stable(crc_s3))
		else $error("stage 3 lost or changed a stalled item");

	// byte counter only moves while a frame is being sent
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> out_valid_q)
		else $error("byte counter nonzero with no frame held");

	// a byte that is not the last is followed by the next byte of the same frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && (cnt_q != LAST_BEAT) |=> out_valid_q && (cnt_q == $past(cnt_q) + 1'b1))
		else $error("frame byte sequence broken");

	// request side is only held off while every crc stage holds an item
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1 && vld_s2 && vld_s3)
		else $error("request stalled with a free stage");

endmodule
